// ===== rtl/ry420_pkg.sv =====
// Shared types, constants and arithmetic helpers for the rgb to yuv 4:2:0 converter.
// No dependencies; used by the top level and its port checker.

package ry420_pkg;

  // payload widths
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 12;
  localparam int FIELD_W = 10;
  localparam int SUM_W   = 3 * FIELD_W;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // luma coefficients, sum is 16 bits before the shift
  localparam logic [15:0] Y_R = 16'd54;
  localparam logic [15:0] Y_G = 16'd183;
  localparam logic [15:0] Y_B = 16'd18;

  // chroma coefficients
  localparam logic signed [17:0] U_R = -18'sd29;
  localparam logic signed [17:0] U_G = -18'sd99;
  localparam logic signed [17:0] U_B = 18'sd128;
  localparam logic signed [17:0] V_R = 18'sd128;
  localparam logic signed [17:0] V_G = -18'sd116;
  localparam logic signed [17:0] V_B = -18'sd12;

  // packed running sums of one block: red low, green middle, blue high
  typedef struct packed {
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] g;
    logic [FIELD_W-1:0] r;
  } block_sum_t;

  // position flags of one pixel, carried down the pipeline
  typedef struct packed {
    logic col_odd;
    logic last_col;
    logic last_row;
    logic bottom_row;
  } pos_t;

  function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [15:0] s;
    s = 16'(r) * Y_R + 16'(g) * Y_G + 16'(b) * Y_B;
    return s[15:8];
  endfunction

  // floor shift by 8, offset by 128, clamp to 0..255
  function automatic logic [PIX_W-1:0] chroma_of(input logic [PIX_W-1:0] ra,
                                                  input logic [PIX_W-1:0] ga,
                                                  input logic [PIX_W-1:0] ba,
                                                  input logic signed [17:0] kr,
                                                  input logic signed [17:0] kg,
                                                  input logic signed [17:0] kb);
    logic signed [17:0] t;
    logic signed [17:0] q;
    t = $signed({10'b0, ra}) * kr + $signed({10'b0, ga}) * kg
        + $signed({10'b0, ba}) * kb;
    q = (t >>> 8) + 18'sd128;
    if (q < 18'sd0) begin
      return '0;
    end else if (q > 18'sd255) begin
      return 8'd255;
    end
    return q[PIX_W-1:0];
  endfunction

endpackage

// ===== rtl/rgb_to_yuv420_convert.sv =====
// Top level of the rgb to yuv 4:2:0 converter: position counters, block sum line store,
// sum stage, chroma stage and output register. Depends on ry420_pkg.
//
//   channel  | direction | handshake                | payload
//   pixel    | in        | pixel_valid / pixel_stall | red, green, blue
//   result   | out       | result_valid / result_stall | luma, chroma_*, frame_end
//   cfg      | in        | cfg_write                | cfg_index, cfg_data
//
// One pixel per clock while no result is held; a taken pixel passes the stage 1 register
// (line store read), stage 2 (sum update) and the output register (chroma math).
// The line store is read on the edge a pixel is taken and written back when that pixel
// leaves stage 1; a write to the entry just read is forwarded.
// Reset clears the counters, the running sums and the pipeline valids; the line store
// is not cleared. A stalled result freezes the whole pipeline and stalls pixels.

module rgb_to_yuv420_convert
  import ry420_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // pixel items
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  // result items
  output logic             result_valid,
  input  logic             result_stall,
  output logic [PIX_W-1:0] luma,
  output logic             chroma_valid,
  output logic [PIX_W-1:0] chroma_u,
  output logic [PIX_W-1:0] chroma_v,
  output logic             frame_end
);

  localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIMW_W  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int DIMH_W  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  // configuration registers
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless a finished result is held
  logic adv;
  logic pix_acc;
  assign adv         = !result_valid || !result_stall;
  assign pixel_stall = !adv;
  assign pix_acc     = pixel_valid && adv;

  // effective frame size, zero as one and oversize as the maximum
  logic [DIMW_W-1:0] w_ext, w_eff;
  logic [DIMH_W-1:0] h_ext, h_eff;
  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  pos_t              pos0;
  logic [ADDR_W-1:0] rd_idx;

  always_comb begin
    w_ext = DIMW_W'(frame_width);
    h_ext = DIMH_W'(frame_height);
    if (w_ext == '0) begin
      w_eff = DIMW_W'(1);
    end else if (w_ext > DIMW_W'(MAX_WIDTH)) begin
      w_eff = DIMW_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = DIMH_W'(1);
    end else if (h_ext > DIMH_W'(MAX_HEIGHT)) begin
      h_eff = DIMH_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    pos0.col_odd    = column_count[0];
    pos0.last_col   = DIMW_W'(column_count) >= (w_eff - DIMW_W'(1));
    pos0.last_row   = DIMH_W'(row_count) >= (h_eff - DIMH_W'(1));
    pos0.bottom_row = row_count[0];
    rd_idx          = ADDR_W'(column_count >> 1);
    // raster position of the next pixel
    if (pos0.last_col) begin
      column_count_next = '0;
      row_count_next    = pos0.last_row ? '0 : row_count + ROW_W'(1);
    end else begin
      column_count_next = column_count + COL_W'(1);
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pix_acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // stage 1: line store read in flight
  logic              v1;
  pos_t              pos1;
  logic [ADDR_W-1:0] idx1;
  logic [PIX_W-1:0]  r1, g1, b1;
  logic              fwd_hit1;
  block_sum_t        fwd_data1;
  block_sum_t        rd_data;
  block_sum_t        sum_mem [STORE_DEPTH];

  // sum update of stage 1
  block_sum_t store_q, base, pair_new, pair_sums;
  logic       close1, complete1, wr_en;

  always_comb begin
    store_q = fwd_hit1 ? fwd_data1 : rd_data;
    if (pos1.col_odd) begin
      base = pair_sums;
    end else if (pos1.bottom_row) begin
      base = store_q;
    end else begin
      base = '0;
    end
    pair_new.r = base.r + FIELD_W'(r1);
    pair_new.g = base.g + FIELD_W'(g1);
    pair_new.b = base.b + FIELD_W'(b1);
    close1     = pos1.col_odd || pos1.last_col;
    complete1  = close1 && (pos1.bottom_row || pos1.last_row);
    wr_en      = adv && v1 && close1 && !complete1;
  end

  // top-row block sums, one entry per block column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[idx1] <= pair_new;
    end
    if (pix_acc) begin
      rd_data <= sum_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pos1      <= pos0;
      idx1      <= rd_idx;
      r1        <= red;
      g1        <= green;
      b1        <= blue;
      // the read above misses a write on the same edge
      fwd_hit1  <= wr_en && (idx1 == rd_idx);
      fwd_data1 <= pair_new;
    end
  end

  // running sums of the current block
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sums <= '0;
    end else if (adv && v1) begin
      pair_sums <= pair_new;
    end
  end

  // stage 2: block averages and luma
  logic             v2, cv2, fe2;
  logic [PIX_W-1:0] ra2, ga2, ba2, luma2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cv2   <= complete1;
      fe2   <= pos1.last_col && pos1.last_row;
      ra2   <= pair_new.r[FIELD_W-1:2];
      ga2   <= pair_new.g[FIELD_W-1:2];
      ba2   <= pair_new.b[FIELD_W-1:2];
      luma2 <= luma_of(r1, g1, b1);
    end
  end

  // stage 3: chroma math into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      luma         <= luma2;
      chroma_valid <= cv2;
      frame_end    <= fe2;
      chroma_u     <= cv2 ? chroma_of(ra2, ga2, ba2, U_R, U_G, U_B) : '0;
      chroma_v     <= cv2 ? chroma_of(ra2, ga2, ba2, V_R, V_G, V_B) : '0;
    end
  end

endmodule

// ===== rtl/ry420_check.sv =====
// Port-level checker for the rgb to yuv 4:2:0 converter, bound to the top level.
// Depends on ry420_pkg.

module ry420_check
  import ry420_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             pixel_stall,
  input logic             result_valid,
  input logic             result_stall,
  input logic [PIX_W-1:0] luma,
  input logic             chroma_valid,
  input logic [PIX_W-1:0] chroma_u,
  input logic [PIX_W-1:0] chroma_v,
  input logic             frame_end
);

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // pixels stall only behind a held result
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    pixel_stall == (result_valid && result_stall))
    else $error("pixel stall does not follow the held result");

  // the last pixel of a frame always closes a block
  a_frame_end_chroma: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_end) |-> chroma_valid)
    else $error("frame end without chroma");

  // chroma fields are zero when no block completes
  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !chroma_valid) |-> (chroma_u == '0 && chroma_v == '0))
    else $error("chroma not zero on a pixel without a block");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(luma)
      && $stable(chroma_u) && $stable(chroma_v)))
    else $error("held result changed");

endmodule

bind rgb_to_yuv420_convert ry420_check u_ry420_check (.*);
